/* hdl/mpct_pkg.sv */
`timescale 1ns / 1ps

package mpct_pkg;

   localparam int POSITION_BITS_DEFAULT = 11;
   localparam int BYTE_BITS             = 8;
   localparam int DELTA_BITS            = 9;
   localparam int CSR_INDEX_BITS        = 2;

   // bit positions inside the first packet byte
   localparam int LEFT_BIT     = 0;
   localparam int RIGHT_BIT    = 1;
   localparam int MIDDLE_BIT   = 2;
   localparam int SYNC_BIT     = 3;
   localparam int X_SIGN_BIT   = 4;
   localparam int Y_SIGN_BIT   = 5;
   localparam int X_OVF_BIT    = 6;
   localparam int Y_OVF_BIT    = 7;

   localparam int X_LOWER_RESET = 0 - 18;
   localparam int X_UPPER_RESET = 800 - 46;
   localparam int Y_LOWER_RESET = 0 - 13;
   localparam int Y_UPPER_RESET = 600 - 50;
   localparam int POINTER_RESET = 100;

   typedef enum logic [1:0] {
      POS_IDLE   = 2'd0,
      POS_SECOND = 2'd1,
      POS_THIRD  = 2'd2
   } byte_pos_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_X_LOWER = 2'd0,
      CSR_X_UPPER = 2'd1,
      CSR_Y_LOWER = 2'd2,
      CSR_Y_UPPER = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                          last_byte;
      logic                          btn_left;
      logic                          btn_right;
      logic                          btn_middle;
      logic                          ovf_x;
      logic                          ovf_y;
      logic signed [DELTA_BITS-1:0]  delta_x;
      logic signed [DELTA_BITS-1:0]  delta_y;
   } packet_type;

endpackage

/* hdl/mpct_if.sv */
`timescale 1ns / 1ps

interface mpct_req_if;
   logic                           valid;
   logic                           ready;
   logic [mpct_pkg::BYTE_BITS-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface mpct_rsp_if #(parameter int POSITION_BITS = mpct_pkg::POSITION_BITS_DEFAULT);
   logic                                   valid;
   logic                                   ready;
   logic                                   btn_left;
   logic                                   btn_right;
   logic                                   btn_middle;
   logic                                   ovf_x;
   logic                                   ovf_y;
   logic signed [mpct_pkg::DELTA_BITS-1:0] delta_x;
   logic signed [mpct_pkg::DELTA_BITS-1:0] delta_y;
   logic signed [POSITION_BITS-1:0]        cursor_x;
   logic signed [POSITION_BITS-1:0]        cursor_y;
   logic                                   position_updated;

   modport source (output valid, output btn_left, output btn_right,
                   output btn_middle, output ovf_x, output ovf_y,
                   output delta_x, output delta_y, output cursor_x, output cursor_y,
                   output position_updated, input ready);
   modport sink (input valid, input btn_left, input btn_right,
                 input btn_middle, input ovf_x, input ovf_y,
                 input delta_x, input delta_y, input cursor_x, input cursor_y,
                 input position_updated, output ready);
endinterface

interface mpct_csr_if #(parameter int POSITION_BITS = mpct_pkg::POSITION_BITS_DEFAULT);
   logic                                valid;
   logic                                ready;
   logic [mpct_pkg::CSR_INDEX_BITS-1:0] index;
   logic [POSITION_BITS-1:0]            data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/mouse_packet_cursor_tracker_unit.sv */
`timescale 1ns / 1ps

// PS/2 mouse packet decoder with a bounded cursor. Mouse bytes enter on req_ch one per
// beat; bytes without the sync bit are dropped until a packet starts, and every third
// packet byte yields one beat on rsp_ch with the buttons, overflow flags, 9-bit deltas
// and the cursor position (x + dx, y - dy, kept only when both lie inside the inclusive
// bounds, flagged by position_updated). The block takes one byte per clock while the
// output is free; a byte is held in the input register, and a third packet byte waits
// there while the output holds an untaken result. The cursor update is one adder
// and two compares per axis between the pointer registers and the output register.
// After reset the cursor is (100, 100) and the bounds are x -18..754, y -13..550;
// csr_ch writes a bound (index 0..3: x lower, x upper, y lower, y upper) and is always
// ready, but should be written only while no packet is in flight.
module mouse_packet_cursor_tracker_unit #(
   parameter int POSITION_BITS = mpct_pkg::POSITION_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mpct_req_if.sink   req_ch,
   mpct_rsp_if.source rsp_ch,
   mpct_csr_if.sink   csr_ch
);

   localparam int SUM_BITS = POSITION_BITS + 1;
   localparam int EXT_BITS = SUM_BITS - mpct_pkg::DELTA_BITS;

   // bounds
   logic [POSITION_BITS-1:0] x_lower_ff, x_upper_ff, y_lower_ff, y_upper_ff;

   // input register
   logic                           in_valid_ff, in_valid_in;
   logic [mpct_pkg::BYTE_BITS-1:0] in_byte_ff;

   // cursor
   logic [POSITION_BITS-1:0] pointer_x_ff, pointer_x_in;
   logic [POSITION_BITS-1:0] pointer_y_ff, pointer_y_in;

   // output register
   logic                                   out_valid_ff, out_valid_in;
   logic                                   left_ff, right_ff, middle_ff;
   logic                                   x_ovf_ff, y_ovf_ff;
   logic signed [mpct_pkg::DELTA_BITS-1:0] delta_x_ff, delta_y_ff;
   logic signed [POSITION_BITS-1:0]        cursor_x_ff, cursor_y_ff;
   logic                                   updated_ff;

   mpct_pkg::packet_type packet;
   logic                 step, out_load, rsp_free;
   logic signed [SUM_BITS-1:0] next_x, next_y;
   logic signed [SUM_BITS-1:0] x_lower_ext, x_upper_ext, y_lower_ext, y_upper_ext;
   logic                 in_bounds;

   mpct_packet_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .packet  (packet)
   );

   assign rsp_free = !out_valid_ff || rsp_ch.ready;
   // a byte that completes no packet moves on even when the output is full
   assign step     = in_valid_ff && (rsp_free || !packet.last_byte);
   assign out_load = step && packet.last_byte;

   assign req_ch.ready = !in_valid_ff || step;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   // candidate position, one bit wider than the cursor so out-of-range sums reject
   always_comb begin
      next_x = $signed({pointer_x_ff[POSITION_BITS-1], pointer_x_ff})
             + $signed({{EXT_BITS{packet.delta_x[mpct_pkg::DELTA_BITS-1]}}, packet.delta_x});
      next_y = $signed({pointer_y_ff[POSITION_BITS-1], pointer_y_ff})
             - $signed({{EXT_BITS{packet.delta_y[mpct_pkg::DELTA_BITS-1]}}, packet.delta_y});
      x_lower_ext = $signed({x_lower_ff[POSITION_BITS-1], x_lower_ff});
      x_upper_ext = $signed({x_upper_ff[POSITION_BITS-1], x_upper_ff});
      y_lower_ext = $signed({y_lower_ff[POSITION_BITS-1], y_lower_ff});
      y_upper_ext = $signed({y_upper_ff[POSITION_BITS-1], y_upper_ff});
      in_bounds = (next_x >= x_lower_ext) && (next_x <= x_upper_ext) &&
                  (next_y >= y_lower_ext) && (next_y <= y_upper_ext);
   end

   always_comb begin
      pointer_x_in = pointer_x_ff;
      pointer_y_in = pointer_y_ff;
      if (out_load && in_bounds) begin
         pointer_x_in = next_x[POSITION_BITS-1:0];
         pointer_y_in = next_y[POSITION_BITS-1:0];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pointer_x_ff <= POSITION_BITS'(mpct_pkg::POINTER_RESET);
         pointer_y_ff <= POSITION_BITS'(mpct_pkg::POINTER_RESET);
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pointer_x_ff <= pointer_x_in;
         pointer_y_ff <= pointer_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_lower_ff <= POSITION_BITS'(mpct_pkg::X_LOWER_RESET);
         x_upper_ff <= POSITION_BITS'(mpct_pkg::X_UPPER_RESET);
         y_lower_ff <= POSITION_BITS'(mpct_pkg::Y_LOWER_RESET);
         y_upper_ff <= POSITION_BITS'(mpct_pkg::Y_UPPER_RESET);
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (mpct_pkg::csr_index_type'(csr_ch.index))
            mpct_pkg::CSR_X_LOWER: x_lower_ff <= csr_ch.data;
            mpct_pkg::CSR_X_UPPER: x_upper_ff <= csr_ch.data;
            mpct_pkg::CSR_Y_LOWER: y_lower_ff <= csr_ch.data;
            mpct_pkg::CSR_Y_UPPER: y_upper_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         left_ff     <= packet.btn_left;
         right_ff    <= packet.btn_right;
         middle_ff   <= packet.btn_middle;
         x_ovf_ff    <= packet.ovf_x;
         y_ovf_ff    <= packet.ovf_y;
         delta_x_ff  <= packet.delta_x;
         delta_y_ff  <= packet.delta_y;
         cursor_x_ff <= pointer_x_in;
         cursor_y_ff <= pointer_y_in;
         updated_ff  <= in_bounds;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.btn_left         = left_ff;
   assign rsp_ch.btn_right        = right_ff;
   assign rsp_ch.btn_middle       = middle_ff;
   assign rsp_ch.ovf_x            = x_ovf_ff;
   assign rsp_ch.ovf_y            = y_ovf_ff;
   assign rsp_ch.delta_x          = delta_x_ff;
   assign rsp_ch.delta_y          = delta_y_ff;
   assign rsp_ch.cursor_x         = cursor_x_ff;
   assign rsp_ch.cursor_y         = cursor_y_ff;
   assign rsp_ch.position_updated = updated_ff;

`ifndef SYNTHESIS
   // a result is never loaded over one that has not been taken
   assert property (@(posedge clock) disable iff (reset)
      out_load |-> rsp_free)
      else $error("result register overwritten while full");

   // a new result beat only comes from a third packet byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(out_load))
      else $error("result beat without a completed packet");

   // a rejected move leaves the cursor alone
   assert property (@(posedge clock) disable iff (reset)
      out_load && !in_bounds |=> $stable(pointer_x_ff) && $stable(pointer_y_ff))
      else $error("cursor moved on a rejected packet");

   // cursor only moves when a packet completes
   assert property (@(posedge clock) disable iff (reset)
      !out_load |=> $stable(pointer_x_ff) && $stable(pointer_y_ff))
      else $error("cursor moved without a packet");
`endif

endmodule

/* hdl/mpct_packet_fsm.sv */
`timescale 1ns / 1ps

module mpct_packet_fsm (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [mpct_pkg::BYTE_BITS-1:0] rx_byte,
   output mpct_pkg::packet_type           packet
);

   mpct_pkg::byte_pos_type         pos_ff, pos_in;
   logic [mpct_pkg::BYTE_BITS-1:0] first_ff, first_in;
   logic [mpct_pkg::BYTE_BITS-1:0] second_ff, second_in;

   // next state
   always_comb begin
      pos_in = pos_ff;
      if (step) begin
         case (pos_ff)
            mpct_pkg::POS_SECOND: pos_in = mpct_pkg::POS_THIRD;
            mpct_pkg::POS_THIRD:  pos_in = mpct_pkg::POS_IDLE;
            default: begin
               // idle (and the spare code): hunt for a byte carrying the sync bit
               pos_in = rx_byte[mpct_pkg::SYNC_BIT] ? mpct_pkg::POS_SECOND
                                                    : mpct_pkg::POS_IDLE;
            end
         endcase
      end
   end

   // byte capture
   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      case (pos_ff)
         mpct_pkg::POS_SECOND: begin
            if (step) second_in = rx_byte;
         end
         mpct_pkg::POS_THIRD: ;
         default: begin
            if (step && rx_byte[mpct_pkg::SYNC_BIT]) first_in = rx_byte;
         end
      endcase
   end

   // outputs
   always_comb begin
      packet = '0;
      case (pos_ff)
         mpct_pkg::POS_THIRD: packet.last_byte = 1'b1;
         default: packet.last_byte = 1'b0;
      endcase
      packet.btn_left   = first_ff[mpct_pkg::LEFT_BIT];
      packet.btn_right  = first_ff[mpct_pkg::RIGHT_BIT];
      packet.btn_middle = first_ff[mpct_pkg::MIDDLE_BIT];
      packet.ovf_x      = first_ff[mpct_pkg::X_OVF_BIT];
      packet.ovf_y      = first_ff[mpct_pkg::Y_OVF_BIT];
      packet.delta_x    = {first_ff[mpct_pkg::X_SIGN_BIT], second_ff};
      packet.delta_y    = {first_ff[mpct_pkg::Y_SIGN_BIT], rx_byte};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= mpct_pkg::POS_IDLE;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
   end

endmodule

/* test/tb_mouse_packet_cursor_tracker_unit.sv */
`timescale 1ns / 1ps

module tb_mouse_packet_cursor_tracker_unit;

   localparam int POS_W          = mpct_pkg::POSITION_BITS_DEFAULT;
   localparam int DELTA_W        = mpct_pkg::DELTA_BITS;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BYTES    = 184;

   typedef struct packed {
      logic                      btn_left;
      logic                      btn_right;
      logic                      btn_middle;
      logic                      ovf_x;
      logic                      ovf_y;
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
      logic signed [POS_W-1:0]   cursor_x;
      logic signed [POS_W-1:0]   cursor_y;
      logic                      position_updated;
   } cursor_report_type;

   // a pinned beat carries a hand-written expectation that replaces the predicted one
   typedef struct packed {
      logic              pinned;
      cursor_report_type want;
   } pin_tag_type;

   typedef enum logic {ROW_BYTES, ROW_BOUNDS} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      int                nbytes;
      logic [0:2][7:0]   rx;
      logic              typed;
      cursor_report_type want;
      int                x_lo;
      int                x_hi;
      int                y_lo;
      int                y_hi;
   } stim_row_type;

   logic clock;
   logic reset;

   mpct_req_if                            req_ch ();
   mpct_rsp_if #(.POSITION_BITS(POS_W))   rsp_ch ();
   mpct_csr_if #(.POSITION_BITS(POS_W))   csr_ch ();

   mouse_packet_cursor_tracker_unit #(.POSITION_BITS(POS_W)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // tracker copy kept alongside the block
   mpct_pkg::byte_pos_type  pkt_pos;
   logic [7:0]              held_first;
   logic [7:0]              held_second;
   logic signed [POS_W-1:0] cur_x;
   logic signed [POS_W-1:0] cur_y;
   logic signed [POS_W-1:0] bound_reg [4];

   cursor_report_type cursor_exp_q [$];
   pin_tag_type       pin_q [$];
   int                mismatch_count;
   int                tx_idle_pct;
   int                rx_idle_pct;

   // starts right after reset: cursor (100,100), x -18..754, y -13..550
   stim_row_type directed_rows [11] = '{
      '{ROW_BYTES, 1, '{8'hF7, 8'h00, 8'h00}, 1'b0, '0, 0, 0, 0, 0},
      '{ROW_BYTES, 3, '{8'h08, 8'h00, 8'h00}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 9'h000, 9'h000, 11'sd100, 11'sd100, 1'b1},
        0, 0, 0, 0},
      '{ROW_BYTES, 3, '{8'hCF, 8'hFF, 8'hFF}, 1'b1,
        '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 9'h0FF, 9'h0FF, 11'sd100, 11'sd100, 1'b0},
        0, 0, 0, 0},
      '{ROW_BYTES, 3, '{8'h3B, 8'h00, 8'h00}, 1'b1,
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 9'h100, 9'h100, 11'sd100, 11'sd100, 1'b0},
        0, 0, 0, 0},
      '{ROW_BYTES, 3, '{8'h08, 8'hFF, 8'h00}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 9'h0FF, 9'h000, 11'sd355, 11'sd100, 1'b1},
        0, 0, 0, 0},
      // x window inverted: nothing can move
      '{ROW_BOUNDS, 0, '0, 1'b0, '0, 1023, -1024, -1024, 1023},
      '{ROW_BYTES, 3, '{8'h08, 8'h00, 8'h00}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 9'h000, 9'h000, 11'sd355, 11'sd100, 1'b0},
        0, 0, 0, 0},
      '{ROW_BOUNDS, 0, '0, 1'b0, '0, -1024, 1023, -1024, 1023},
      '{ROW_BYTES, 3, '{8'h08, 8'hFF, 8'h00}, 1'b0, '0, 0, 0, 0, 0},
      '{ROW_BYTES, 3, '{8'h08, 8'hFF, 8'h00}, 1'b0, '0, 0, 0, 0, 0},
      // 865 + 255 leaves the 11-bit range; the truncated value would sit in bounds
      '{ROW_BYTES, 3, '{8'h08, 8'hFF, 8'h00}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 9'h0FF, 9'h000, 11'sd865, 11'sd100, 1'b0},
        0, 0, 0, 0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void track_mouse_byte(input logic [7:0] value, output bit produced,
                                            output cursor_report_type rpt);
      int  dx;
      int  dy;
      int  nx;
      int  ny;
      bit  ok;
      produced = 1'b0;
      rpt      = '0;
      case (pkt_pos)
         mpct_pkg::POS_SECOND: begin
            held_second = value;
            pkt_pos     = mpct_pkg::POS_THIRD;
         end
         mpct_pkg::POS_THIRD: begin
            pkt_pos = mpct_pkg::POS_IDLE;
            dx = held_first[mpct_pkg::X_SIGN_BIT] ? int'(held_second) - 256
                                                  : int'(held_second);
            dy = held_first[mpct_pkg::Y_SIGN_BIT] ? int'(value) - 256 : int'(value);
            // compare on the full sum, not the truncated one
            nx = int'(cur_x) + dx;
            ny = int'(cur_y) - dy;
            ok = nx >= int'(bound_reg[mpct_pkg::CSR_X_LOWER]) &&
                 nx <= int'(bound_reg[mpct_pkg::CSR_X_UPPER]) &&
                 ny >= int'(bound_reg[mpct_pkg::CSR_Y_LOWER]) &&
                 ny <= int'(bound_reg[mpct_pkg::CSR_Y_UPPER]);
            if (ok) begin
               cur_x = nx[POS_W-1:0];
               cur_y = ny[POS_W-1:0];
            end
            rpt.btn_left         = held_first[mpct_pkg::LEFT_BIT];
            rpt.btn_right        = held_first[mpct_pkg::RIGHT_BIT];
            rpt.btn_middle       = held_first[mpct_pkg::MIDDLE_BIT];
            rpt.ovf_x            = held_first[mpct_pkg::X_OVF_BIT];
            rpt.ovf_y            = held_first[mpct_pkg::Y_OVF_BIT];
            rpt.delta_x          = dx[DELTA_W-1:0];
            rpt.delta_y          = dy[DELTA_W-1:0];
            rpt.cursor_x         = cur_x;
            rpt.cursor_y         = cur_y;
            rpt.position_updated = ok;
            produced = 1'b1;
         end
         default: begin
            // idle, and the unused position code behaves the same
            if (value[mpct_pkg::SYNC_BIT]) begin
               held_first = value;
               pkt_pos    = mpct_pkg::POS_SECOND;
            end else begin
               pkt_pos = mpct_pkg::POS_IDLE;
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic compare_report(input cursor_report_type got,
                                 input cursor_report_type want);
      if (got.btn_left !== want.btn_left)
         report_mismatch($sformatf("btn_left got %0b want %0b", got.btn_left,
                                   want.btn_left));
      if (got.btn_right !== want.btn_right)
         report_mismatch($sformatf("btn_right got %0b want %0b", got.btn_right,
                                   want.btn_right));
      if (got.btn_middle !== want.btn_middle)
         report_mismatch($sformatf("btn_middle got %0b want %0b", got.btn_middle,
                                   want.btn_middle));
      if (got.ovf_x !== want.ovf_x)
         report_mismatch($sformatf("ovf_x got %0b want %0b", got.ovf_x, want.ovf_x));
      if (got.ovf_y !== want.ovf_y)
         report_mismatch($sformatf("ovf_y got %0b want %0b", got.ovf_y, want.ovf_y));
      if (got.delta_x !== want.delta_x)
         report_mismatch($sformatf("delta_x got %0d want %0d", got.delta_x, want.delta_x));
      if (got.delta_y !== want.delta_y)
         report_mismatch($sformatf("delta_y got %0d want %0d", got.delta_y, want.delta_y));
      if (got.cursor_x !== want.cursor_x)
         report_mismatch($sformatf("cursor_x got %0d want %0d", got.cursor_x, want.cursor_x));
      if (got.cursor_y !== want.cursor_y)
         report_mismatch($sformatf("cursor_y got %0d want %0d", got.cursor_y, want.cursor_y));
      if (got.position_updated !== want.position_updated)
         report_mismatch($sformatf("position_updated got %0b want %0b",
                                   got.position_updated, want.position_updated));
   endtask

   always @(posedge clock) begin
      pin_tag_type       tag;
      cursor_report_type predicted;
      cursor_report_type seen;
      bit                produced;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            bound_reg[csr_ch.index] = csr_ch.data;
         end
         if (req_ch.valid && req_ch.ready) begin
            tag = pin_q.pop_front();
            track_mouse_byte(req_ch.rx_byte, produced, predicted);
            if (produced) begin
               cursor_exp_q.push_back(tag.pinned ? tag.want : predicted);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.btn_left         = rsp_ch.btn_left;
            seen.btn_right        = rsp_ch.btn_right;
            seen.btn_middle       = rsp_ch.btn_middle;
            seen.ovf_x            = rsp_ch.ovf_x;
            seen.ovf_y            = rsp_ch.ovf_y;
            seen.delta_x          = rsp_ch.delta_x;
            seen.delta_y          = rsp_ch.delta_y;
            seen.cursor_x         = rsp_ch.cursor_x;
            seen.cursor_y         = rsp_ch.cursor_y;
            seen.position_updated = rsp_ch.position_updated;
            if (cursor_exp_q.size() == 0) begin
               report_mismatch("result beat with no packet pending");
            end else begin
               compare_report(seen, cursor_exp_q.pop_front());
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic push_rx_byte(input logic [7:0] value, input logic pinned,
                               input cursor_report_type want);
      pin_tag_type tag;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      tag.pinned = pinned;
      tag.want   = want;
      pin_q.push_back(tag);
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // hold the sender until every pending packet has come out, then let the pipe drain
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (cursor_exp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_bounds(input int x_lo, input int x_hi, input int y_lo, input int y_hi);
      int                      vals [4];
      mpct_pkg::csr_index_type order [4];
      vals  = '{x_lo, x_hi, y_lo, y_hi};
      order = '{mpct_pkg::CSR_X_LOWER, mpct_pkg::CSR_X_UPPER,
                mpct_pkg::CSR_Y_LOWER, mpct_pkg::CSR_Y_UPPER};
      for (int i = 0; i < 4; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= order[i];
         csr_ch.data  <= vals[i][POS_W-1:0];
         do @(posedge clock); while (!csr_ch.ready);
      end
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [8:0] pick_delta();
      case ($urandom_range(3))
         0: return 9'($urandom_range(16)) - 9'd8;
         1: begin
            case ($urandom_range(3))
               0: return 9'h100;
               1: return 9'h0FF;
               2: return 9'h1FF;
               default: return 9'h000;
            endcase
         end
         default: return 9'($urandom_range(511));
      endcase
   endfunction

   function automatic int clamp_pos(input int v);
      if (v < -1024) return -1024;
      if (v > 1023) return 1023;
      return v;
   endfunction

   initial begin
      int         sent;
      int         span;
      int         x_lo;
      int         x_hi;
      int         y_lo;
      int         y_hi;
      logic [8:0] dx;
      logic [8:0] dy;
      logic [7:0] head;

      mismatch_count = 0;
      tx_idle_pct    = 30;
      rx_idle_pct    = 66;
      pkt_pos        = mpct_pkg::POS_IDLE;
      held_first     = '0;
      held_second    = '0;
      cur_x          = POS_W'(mpct_pkg::POINTER_RESET);
      cur_y          = POS_W'(mpct_pkg::POINTER_RESET);
      bound_reg[mpct_pkg::CSR_X_LOWER] = POS_W'(mpct_pkg::X_LOWER_RESET);
      bound_reg[mpct_pkg::CSR_X_UPPER] = POS_W'(mpct_pkg::X_UPPER_RESET);
      bound_reg[mpct_pkg::CSR_Y_LOWER] = POS_W'(mpct_pkg::Y_LOWER_RESET);
      bound_reg[mpct_pkg::CSR_Y_UPPER] = POS_W'(mpct_pkg::Y_UPPER_RESET);

      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.index   <= mpct_pkg::CSR_X_LOWER;
      csr_ch.data    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_BOUNDS) begin
            settle_block();
            load_bounds(directed_rows[r].x_lo, directed_rows[r].x_hi,
                        directed_rows[r].y_lo, directed_rows[r].y_hi);
         end else begin
            for (int k = 0; k < directed_rows[r].nbytes; k++) begin
               push_rx_byte(directed_rows[r].rx[k],
                            directed_rows[r].typed && (k == directed_rows[r].nbytes - 1),
                            directed_rows[r].want);
            end
         end
      end

      for (int ph = 0; ph < 6; ph++) begin
         if (ph < 2) begin
            tx_idle_pct = 30;
            rx_idle_pct = 66;
         end else if (ph < 4) begin
            tx_idle_pct = 66;
            rx_idle_pct = 30;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         settle_block();
         case (ph)
            0: begin
               x_lo = -1024; x_hi = 1023; y_lo = -1024; y_hi = 1023;
            end
            1: begin
               x_lo = -$urandom_range(600); x_hi = $urandom_range(900);
               y_lo = -$urandom_range(600); y_hi = $urandom_range(900);
            end
            2: begin
               x_lo = 1023; x_hi = -1024;
               y_lo = -$urandom_range(1024); y_hi = $urandom_range(1023);
            end
            3: begin
               // tight window around wherever the cursor sits now
               span = $urandom_range(64);
               x_lo = clamp_pos(int'(cur_x) - span); x_hi = clamp_pos(int'(cur_x) + span);
               span = $urandom_range(64);
               y_lo = clamp_pos(int'(cur_y) - span); y_hi = clamp_pos(int'(cur_y) + span);
            end
            4: begin
               x_lo = int'($urandom_range(2047)) - 1024; x_hi = int'($urandom_range(2047)) - 1024;
               y_lo = int'($urandom_range(2047)) - 1024; y_hi = int'($urandom_range(2047)) - 1024;
            end
            default: begin
               x_lo = mpct_pkg::X_LOWER_RESET; x_hi = mpct_pkg::X_UPPER_RESET;
               y_lo = mpct_pkg::Y_LOWER_RESET; y_hi = mpct_pkg::Y_UPPER_RESET;
            end
         endcase
         load_bounds(x_lo, x_hi, y_lo, y_hi);

         sent = 0;
         while (sent < PHASE_BYTES) begin
            // stray byte without sync between packets, dropped by the block
            if ($urandom_range(9) == 0) begin
               head = 8'($urandom);
               head[mpct_pkg::SYNC_BIT] = 1'b0;
               push_rx_byte(head, 1'b0, '0);
            end
            dx   = pick_delta();
            dy   = pick_delta();
            head = 8'($urandom);
            head[mpct_pkg::SYNC_BIT]   = 1'b1;
            head[mpct_pkg::X_SIGN_BIT] = dx[8];
            head[mpct_pkg::Y_SIGN_BIT] = dy[8];
            push_rx_byte(head, 1'b0, '0);
            push_rx_byte(dx[7:0], 1'b0, '0);
            push_rx_byte(dy[7:0], 1'b0, '0);
            sent += 3;
            if ($urandom_range(149) == 0) begin
               settle_block();
            end
         end
      end

      settle_block();
      if (mismatch_count == 0 && cursor_exp_q.size() == 0) begin
         $display("mouse_packet_cursor_tracker_unit regression: pass");
      end else begin
         $display("mouse_packet_cursor_tracker_unit regression: fail");
      end
      $finish;
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("mouse_packet_cursor_tracker_unit regression: fail");
      $finish;
   end

endmodule
